FILE: sv/wavs_pkg.sv
// Shared word types for the WAV stream to stereo frame converter.
package wavs_pkg;

  // One input word: stream restart flag and the next stream byte.
  typedef struct packed {
    logic       start_stream;
    logic [7:0] data_byte;
  } wav_in_t;

  // One output word: a stereo frame with the format in force.
  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
  } wav_out_t;

endpackage

FILE: sv/wavs_parser.sv
// RIFF/WAVE header walker and PCM-to-frame assembler, one byte per step.
module wavs_parser
  import wavs_pkg::*;
#(
  parameter int unsigned HEADER_MAX = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  wav_in_t  in_i,
  output logic     res_valid_o,
  output wav_out_t res_o
);

  localparam int unsigned PW = $clog2(HEADER_MAX + 1);
  localparam int unsigned SW = $clog2(HEADER_MAX + 2);

  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_WAVE = 3'd2;
  localparam logic [2:0] PH_CHDR = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;
  localparam logic [2:0] PH_PCM  = 3'd5;
  localparam logic [2:0] PH_DROP = 3'd6;

  // Tags held little-endian: byte n sits at bits [8n+7:8n].
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] DEFAULT_RATE     = 32'd24000;
  localparam logic [15:0] DEFAULT_CHANNELS = 16'd1;

  logic [2:0]    phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0]   size_q, size_d;
  logic [SW-1:0] skip_q, skip_d;
  logic [1:0]    match_q, match_d;   // bit 0: still fmt, bit 1: still data
  logic [47:0]   cap_q, cap_d;
  logic [31:0]   rate_q, rate_d;
  logic [15:0]   chan_q, chan_d;
  logic [7:0]    low_q, low_d;
  logic          have_low_q, have_low_d;
  logic [15:0]   held_q, held_d;
  logic          have_left_q, have_left_d;

  always_comb begin
    logic [7:0]    b;
    logic [PW-1:0] k;
    logic [2:0]    hi;
    logic [SW-1:0] bi;
    logic [31:0]   padded;
    logic [15:0]   s;

    b      = in_i.data_byte;
    k      = '0;
    hi     = '0;
    bi     = '0;
    padded = '0;
    s      = '0;

    phase_d     = phase_q;
    pos_d       = pos_q;
    size_d      = size_q;
    skip_d      = skip_q;
    match_d     = match_q;
    cap_d       = cap_q;
    rate_d      = rate_q;
    chan_d      = chan_q;
    low_d       = low_q;
    have_low_d  = have_low_q;
    held_d      = held_q;
    have_left_d = have_left_q;

    res_valid_o = 1'b0;
    res_o       = '0;

    // Restart: this byte is parsed against the reset state.
    if (step_i && in_i.start_stream) begin
      phase_d     = PH_RIFF;
      pos_d       = '0;
      size_d      = '0;
      skip_d      = '0;
      match_d     = '0;
      cap_d       = '0;
      rate_d      = DEFAULT_RATE;
      chan_d      = DEFAULT_CHANNELS;
      low_d       = '0;
      have_low_d  = 1'b0;
      held_d      = '0;
      have_left_d = 1'b0;
    end

    if (step_i && phase_d != PH_DROP) begin
      if (phase_d != PH_PCM) begin
        if (pos_d >= PW'(HEADER_MAX)) begin
          phase_d = PH_DROP;
        end else begin
          k     = pos_d;
          pos_d = k + PW'(1);
          case (phase_d)
            PH_RIFF: begin
              if (b != TAG_RIFF[{k[1:0], 3'b000} +: 8]) phase_d = PH_DROP;
              else if (k == PW'(3)) phase_d = PH_SIZE;
            end
            PH_SIZE: begin
              if (k == PW'(7)) phase_d = PH_WAVE;
            end
            PH_WAVE: begin
              if (b != TAG_WAVE[{k[1:0], 3'b000} +: 8]) begin
                phase_d = PH_DROP;
              end else if (k == PW'(11)) begin
                phase_d = PH_CHDR;
                skip_d  = '0;
              end
            end
            PH_CHDR: begin
              hi = skip_d[2:0];
              if (hi == 3'd0) begin
                size_d  = '0;
                match_d = 2'b11;
                cap_d   = '0;
              end
              if (!hi[2]) begin
                if (b != TAG_FMT[{hi[1:0], 3'b000} +: 8])  match_d[0] = 1'b0;
                if (b != TAG_DATA[{hi[1:0], 3'b000} +: 8]) match_d[1] = 1'b0;
              end else begin
                size_d[{hi[1:0], 3'b000} +: 8] = b;
              end
              if (hi != 3'd7) begin
                skip_d = SW'(hi) + SW'(1);
              end else if (match_d[1]) begin
                phase_d     = PH_PCM;
                have_low_d  = 1'b0;
                have_left_d = 1'b0;
              end else if (size_d > 32'(HEADER_MAX)) begin
                phase_d = PH_DROP;
              end else begin
                // Pad odd bodies to an even length.
                padded = size_d + {31'b0, size_d[0]};
                size_d = padded;
                if (padded == 32'd0) begin
                  phase_d = PH_CHDR;
                  skip_d  = '0;
                end else begin
                  skip_d  = padded[SW-1:0];
                  phase_d = PH_BODY;
                end
              end
            end
            PH_BODY: begin
              bi = size_d[SW-1:0] - skip_d;
              if (match_d[0] && bi >= SW'(2) && bi <= SW'(7)) begin
                cap_d[{3'(bi[2:0] - 3'd2), 3'b000} +: 8] = b;
              end
              if (match_d[0] && bi == SW'(15)) begin
                chan_d = cap_d[15:0];
                rate_d = cap_d[47:16];
              end
              skip_d = skip_d - SW'(1);
              if (skip_d == '0) phase_d = PH_CHDR;
            end
            default: begin
              phase_d = PH_DROP;
            end
          endcase
        end
      end else begin
        if (!have_low_d) begin
          low_d      = b;
          have_low_d = 1'b1;
        end else begin
          have_low_d = 1'b0;
          s          = {b, low_d};
          if (chan_d == 16'd2) begin
            if (!have_left_d) begin
              held_d      = s;
              have_left_d = 1'b1;
            end else begin
              have_left_d        = 1'b0;
              res_valid_o        = 1'b1;
              res_o.left_sample  = held_d;
              res_o.right_sample = s;
            end
          end else begin
            res_valid_o        = 1'b1;
            res_o.left_sample  = s;
            res_o.right_sample = s;
          end
          res_o.sample_rate   = rate_d;
          res_o.channel_count = chan_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      pos_q       <= '0;
      size_q      <= '0;
      skip_q      <= '0;
      match_q     <= '0;
      cap_q       <= '0;
      rate_q      <= DEFAULT_RATE;
      chan_q      <= DEFAULT_CHANNELS;
      low_q       <= '0;
      have_low_q  <= 1'b0;
      held_q      <= '0;
      have_left_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      size_q      <= size_d;
      skip_q      <= skip_d;
      match_q     <= match_d;
      cap_q       <= cap_d;
      rate_q      <= rate_d;
      chan_q      <= chan_d;
      low_q       <= low_d;
      have_low_q  <= have_low_d;
      held_q      <= held_d;
      have_left_q <= have_left_d;
    end
  end

endmodule

FILE: sv/wavs_out_buf.sv
// Two-word output buffer holding finished frames until the consumer takes them.
module wavs_out_buf
  import wavs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  wav_out_t   push_data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output wav_out_t   data_o,
  output logic [1:0] level_o
);

  logic [1:0] level_q, level_d;
  wav_out_t   head_q, head_d;
  wav_out_t   tail_q, tail_d;
  logic       pop;
  logic [1:0] after_pop;

  assign valid_o = (level_q != 2'd0);
  assign data_o  = head_q;
  assign level_o = level_q;
  assign pop     = valid_o && ready_i;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    after_pop = level_q - {1'b0, pop};
    // Advance the tail word into the head on a pop.
    if (pop) head_d = tail_q;
    if (push_i) begin
      if (after_pop == 2'd0) head_d = push_data_i;
      else tail_d = push_data_i;
    end
    level_d = after_pop + {1'b0, push_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

FILE: sv/wav_stream_to_stereo_frames.sv
// Top level: WAV byte stream in, 16-bit stereo frames out.
// Takes one stream byte per cycle while in_ready_o is high. The byte is
// parsed in the cycle it is accepted and any frame it completes is written
// into a two-word output buffer that presents it once older words are taken.
// in_ready_o is low only while both buffer words are full; a consumer that
// takes a word every cycle never stalls the byte side. Raising start_stream
// with a byte restarts the parser and restores 24000 Hz mono. Headers longer
// than HEADER_MAX bytes, non-data chunks larger than HEADER_MAX, or bad
// RIFF/WAVE tags drop the rest of the stream. No clearing pass after reset.
module wav_stream_to_stereo_frames
  import wavs_pkg::*;
#(
  parameter int unsigned HEADER_MAX = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wav_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wav_out_t out_data_o
);

  logic       step;
  logic       res_valid;
  wav_out_t   res;
  logic [1:0] level;

  assign in_ready_o = (level != 2'd2);
  assign step       = in_valid_i && in_ready_o;

  wavs_parser #(
    .HEADER_MAX(HEADER_MAX)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .in_i       (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wavs_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_data_o),
    .level_o    (level)
  );

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level != 2'd3)
    else $error("output buffer level out of range");

  a_frame_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> step)
    else $error("frame produced without an accepted word");

  a_restart_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_data_i.start_stream |-> !res_valid)
    else $error("frame produced by a restart word");

  a_mono_duplicate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.channel_count != 16'd2 |->
      out_data_o.left_sample == out_data_o.right_sample)
    else $error("non-stereo frame with differing sides");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the WAV byte stream to stereo frame converter.
`timescale 1ns / 1ps

module tb;
  import wavs_pkg::*;

  localparam int unsigned HDR_MAX = 256;
  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";
  localparam logic [31:0] DEF_RATE = 32'd24000;
  localparam logic [15:0] DEF_CHANS = 16'd1;
  // Samples -32768, 32767, 0 and -1, little-endian.
  localparam logic [63:0] EXTREME_PCM = 64'h0080_FF7F_0000_FFFF;

  typedef enum logic [2:0] {
    ST_RIFF, ST_SIZE, ST_WAVE, ST_CHDR, ST_BODY, ST_PCM, ST_DROP
  } parse_state_e;

  typedef struct packed {
    bit      drain;
    wav_in_t word;
  } byte_plan_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready_o;
  wav_in_t  in_data = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  wav_out_t out_data_o;

  byte_plan_t byte_queue[$];
  wav_out_t   frame_queue[$];

  int err_count = 0;
  int bytes_taken = 0;
  int frames_seen = 0;
  int stereo_frames = 0;
  int stream_count = 0;
  int tx_idle = 0;
  bit tx_steady = 1'b0;
  int rx_stall = 0;
  int rx_hold = 0;
  bit rx_steady = 1'b0;

  // Parser state as seen from outside.
  parse_state_e ph;
  int unsigned  hdr_pos;
  logic [31:0]  size_acc;
  logic [31:0]  chunk_cnt;
  logic [1:0]   id_match;   // bit 0: still "fmt ", bit 1: still "data"
  logic [47:0]  fmt_bits;
  logic [31:0]  cur_rate;
  logic [15:0]  cur_chans;
  logic [7:0]   lo_byte;
  bit           lo_valid;
  logic [15:0]  left_hold;
  bit           left_valid;

  wav_stream_to_stereo_frames #(.HEADER_MAX(HDR_MAX)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] tag_byte(input logic [31:0] t, input int unsigned i);
    return t[8*(3-i) +: 8];
  endfunction

  function automatic void restart_parser();
    ph = ST_RIFF;
    hdr_pos = 0;
    size_acc = '0;
    chunk_cnt = '0;
    id_match = '0;
    fmt_bits = '0;
    cur_rate = DEF_RATE;
    cur_chans = DEF_CHANS;
    lo_byte = '0;
    lo_valid = 1'b0;
    left_hold = '0;
    left_valid = 1'b0;
  endfunction

  function automatic void header_step(input logic [7:0] b);
    int unsigned k;
    int unsigned i;
    k = hdr_pos;
    hdr_pos = k + 1;
    case (ph)
      ST_RIFF: begin
        if (b != tag_byte(TAG_RIFF, k % 4)) ph = ST_DROP;
        else if (k == 3) ph = ST_SIZE;
      end
      ST_SIZE: begin
        if (k == 7) ph = ST_WAVE;
      end
      ST_WAVE: begin
        if (b != tag_byte(TAG_WAVE, k % 4)) ph = ST_DROP;
        else if (k == 11) begin
          ph = ST_CHDR;
          chunk_cnt = '0;
        end
      end
      ST_CHDR: begin
        i = 32'(chunk_cnt[2:0]);
        if (i == 0) begin
          size_acc = '0;
          id_match = 2'b11;
          fmt_bits = '0;
        end
        if (i < 4) begin
          if (b != tag_byte(TAG_FMT, i)) id_match[0] = 1'b0;
          if (b != tag_byte(TAG_DATA, i)) id_match[1] = 1'b0;
        end else begin
          size_acc = size_acc | (32'(b) << (8*(i-4)));
        end
        i++;
        if (i < 8) begin
          chunk_cnt = i;
        end else if (id_match[1]) begin
          ph = ST_PCM;
          lo_valid = 1'b0;
          left_valid = 1'b0;
        end else if (size_acc > HDR_MAX) begin
          ph = ST_DROP;
        end else begin
          // pad odd bodies to even length
          size_acc = size_acc + 32'(size_acc[0]);
          if (size_acc == 0) begin
            chunk_cnt = '0;
          end else begin
            chunk_cnt = size_acc;
            ph = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        i = size_acc - chunk_cnt;
        if (id_match[0] && i >= 2 && i <= 7)
          fmt_bits = fmt_bits | (48'(b) << (8*(i-2)));
        if (id_match[0] && i == 15) begin
          cur_chans = fmt_bits[15:0];
          cur_rate = fmt_bits[47:16];
        end
        chunk_cnt = chunk_cnt - 1;
        if (chunk_cnt == 0) ph = ST_CHDR;
      end
      default: ph = ST_DROP;
    endcase
  endfunction

  // Advance the parser by one accepted word and queue any frame it completes.
  function automatic void parse_byte(input wav_in_t w);
    logic [15:0] smp;
    wav_out_t f;
    if (w.start_stream) restart_parser();
    if (ph == ST_DROP) return;
    if (ph != ST_PCM) begin
      if (hdr_pos >= HDR_MAX) ph = ST_DROP;
      else header_step(w.data_byte);
      return;
    end
    if (!lo_valid) begin
      lo_byte = w.data_byte;
      lo_valid = 1'b1;
      return;
    end
    lo_valid = 1'b0;
    smp = {w.data_byte, lo_byte};
    if (cur_chans == 16'd2) begin
      if (!left_valid) begin
        left_hold = smp;
        left_valid = 1'b1;
        return;
      end
      left_valid = 1'b0;
      f.left_sample = left_hold;
      f.right_sample = smp;
    end else begin
      f.left_sample = smp;
      f.right_sample = smp;
    end
    f.sample_rate = cur_rate;
    f.channel_count = cur_chans;
    frame_queue.push_back(f);
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    if (err_count < 20)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    err_count++;
  endtask

  task automatic check_frame(input wav_out_t got);
    wav_out_t want;
    if (frame_queue.size() == 0) begin
      report("unexpected frame", 32'(got.left_sample), '0);
      return;
    end
    want = frame_queue.pop_front();
    if (got.left_sample !== want.left_sample)
      report("left_sample", 32'(got.left_sample), 32'(want.left_sample));
    if (got.right_sample !== want.right_sample)
      report("right_sample", 32'(got.right_sample), 32'(want.right_sample));
    if (got.sample_rate !== want.sample_rate)
      report("sample_rate", got.sample_rate, want.sample_rate);
    if (got.channel_count !== want.channel_count)
      report("channel_count", 32'(got.channel_count), 32'(want.channel_count));
    if (want.channel_count == 16'd2) stereo_frames++;
  endtask

  // Mostly short gaps, a few long ones, none at all in steady stretches.
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: offer the front word and hold it until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    bit nxt_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      tx_idle = 0;
      restart_parser();
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready_o) begin
        parse_byte(in_data);
        bytes_taken++;
        nxt_valid = 1'b0;
        if ($urandom_range(0, 149) == 0) tx_steady = !tx_steady;
        tx_idle = pick_gap(tx_steady);
      end
      if (!nxt_valid) begin
        if (tx_idle > 0) begin
          tx_idle--;
        end else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].drain && frame_queue.size() > 0)) begin
          in_data <= byte_queue[0].word;
          void'(byte_queue.pop_front());
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: check each frame; hold off for long stretches twice.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    bit nxt_ready;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_stall = 0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        check_frame(out_data_o);
        frames_seen++;
        if (frames_seen == 10 || frames_seen == 40) rx_hold = 300;
        if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        nxt_ready = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if ($urandom_range(0, 99) < 25) rx_stall = pick_gap(rx_steady);
      end
      out_ready <= nxt_ready;
    end
  end

  task automatic put(input logic [7:0] b, input bit first, input bit drain);
    byte_plan_t p;
    p.drain = drain;
    p.word.start_stream = first;
    p.word.data_byte = b;
    byte_queue.push_back(p);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int j = 0; j < n; j++) put(v[8*j +: 8], 1'b0, 1'b0);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int j = 0; j < 4; j++) put(tag_byte(t, j), 1'b0, 1'b0);
  endtask

  task automatic riff_head(input logic [31:0] riff, input logic [31:0] wave, input bit drain);
    stream_count++;
    put(riff[31:24], 1'b1, drain);
    put(riff[23:16], 1'b0, 1'b0);
    put(riff[15:8], 1'b0, 1'b0);
    put(riff[7:0], 1'b0, 1'b0);
    put_le($urandom, 4);
    put_tag(wave);
  endtask

  task automatic other_chunk(input logic [31:0] id, input logic [31:0] size, input int body);
    put_tag(id);
    put_le(size, 4);
    for (int j = 0; j < body; j++) put(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic fmt_chunk(input logic [15:0] chans, input logic [31:0] rate,
                           input int unsigned size);
    int unsigned padded;
    logic [7:0] b;
    padded = size + (size % 2);
    put_tag(TAG_FMT);
    put_le(size, 4);
    for (int unsigned j = 0; j < padded; j++) begin
      case (j)
        0: b = 8'd1;
        1: b = 8'd0;
        2, 3: b = chans[8*(j-2) +: 8];
        4, 5, 6, 7: b = rate[8*(j-4) +: 8];
        default: b = 8'($urandom);
      endcase
      put(b, 1'b0, 1'b0);
    end
  endtask

  task automatic data_head();
    put_tag(TAG_DATA);
    put_le($urandom, 4);
  endtask

  task automatic put_pcm(input int n, input bit extremes);
    for (int j = 0; j < n; j++)
      put(extremes ? EXTREME_PCM[8*(7-(j%8)) +: 8] : 8'($urandom), 1'b0, 1'b0);
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return 32'd8000;
      1: return 32'd16000;
      2: return 32'd22050;
      3: return 32'd24000;
      4: return 32'd44100;
      5: return 32'd48000;
      6: return 32'd96000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 3))
      0: return "LIST";
      1: return "fact";
      2: return "JUNK";
      default: return "cue ";
    endcase
  endfunction

  task automatic well_formed_stream(inout int wf_bytes, inout int pcm_bytes);
    int mark;
    int r;
    int sz;
    int len;
    logic [15:0] chans;
    mark = byte_queue.size();
    riff_head(TAG_RIFF, TAG_WAVE, $urandom_range(0, 19) == 0);
    if ($urandom_range(0, 1)) begin
      sz = $urandom_range(0, 21);
      other_chunk(pick_id(), sz, sz + sz % 2);
    end
    if ($urandom_range(0, 9) != 0) begin
      r = $urandom_range(0, 99);
      chans = (r < 50) ? 16'd2 : (r < 75) ? 16'd1 : 16'($urandom);
      r = $urandom_range(0, 99);
      fmt_chunk(chans, pick_rate(), (r < 75) ? 16 : (r < 90) ? 18 : $urandom_range(0, 15));
      if ($urandom_range(0, 7) == 0) fmt_chunk(16'd2, pick_rate(), $urandom_range(12, 18));
    end
    if ($urandom_range(0, 2) == 0) begin
      sz = $urandom_range(0, 21);
      other_chunk(pick_id(), sz, sz + sz % 2);
    end
    data_head();
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 40) : $urandom_range(60, 160);
    put_pcm(len, $urandom_range(0, 9) == 0);
    wf_bytes += byte_queue.size() - mark;
    pcm_bytes += len;
  endtask

  // Broken or noisy streams: bad tags, oversized chunks, raw bytes.
  task automatic broken_stream();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      if ($urandom_range(0, 1))
        riff_head(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)), TAG_WAVE, 1'b0);
      else
        riff_head(TAG_RIFF, TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)), 1'b0);
      put_pcm($urandom_range(4, 20), 1'b0);
    end else if (r < 70) begin
      riff_head(TAG_RIFF, TAG_WAVE, 1'b0);
      other_chunk(pick_id(), $urandom_range(0, 1) ? $urandom | 32'h200 : HDR_MAX + 1, 6);
      data_head();
      put_pcm($urandom_range(2, 12), 1'b0);
    end else begin
      put(8'($urandom), 1'b1, 1'b0);
      for (int j = $urandom_range(4, 24); j > 0; j--)
        put(8'($urandom), $urandom_range(0, 15) == 0, 1'b0);
    end
  endtask

  initial begin : main
    int wf_bytes;
    int pcm_bytes;
    wf_bytes = 0;
    pcm_bytes = 0;

    // Stereo with extreme samples; the trailing odd byte stays held.
    riff_head(TAG_RIFF, TAG_WAVE, 1'b0);
    fmt_chunk(16'd2, 32'd44100, 16);
    data_head();
    put_pcm(17, 1'b1);
    // No fmt: defaults apply; odd-sized and empty chunks are walked past.
    riff_head(TAG_RIFF, TAG_WAVE, 1'b1);
    other_chunk("LIST", 32'd3, 4);
    other_chunk("JUNK", 32'd0, 0);
    data_head();
    put_pcm(8, 1'b1);
    // Several fmt chunks: the last complete one wins, a short one is ignored.
    riff_head(TAG_RIFF, TAG_WAVE, 1'b0);
    fmt_chunk(16'd0, 32'd0, 16);
    fmt_chunk(16'hFFFF, 32'hFFFF_FFFF, 18);
    fmt_chunk(16'd2, 32'd8000, 14);
    data_head();
    put_pcm(8, 1'b1);
    // Zero channels: each sample goes to both sides.
    riff_head(TAG_RIFF, TAG_WAVE, 1'b0);
    fmt_chunk(16'd0, 32'd0, 16);
    data_head();
    put_pcm(6, 1'b0);
    // Bad RIFF tag, then bad WAVE tag: everything after is dropped.
    riff_head("RIFX", TAG_WAVE, 1'b0);
    data_head();
    put_pcm(6, 1'b0);
    riff_head(TAG_RIFF, "WAVF", 1'b0);
    data_head();
    put_pcm(6, 1'b0);
    // Non-data chunk just over the limit.
    riff_head(TAG_RIFF, TAG_WAVE, 1'b0);
    other_chunk("LIST", HDR_MAX + 1, 4);
    data_head();
    put_pcm(6, 1'b0);
    // Chunk at the limit pushes the header past HEADER_MAX.
    riff_head(TAG_RIFF, TAG_WAVE, 1'b0);
    other_chunk("LIST", HDR_MAX, HDR_MAX);
    data_head();
    put_pcm(6, 1'b0);
    // Stereo cut short: one frame then a lone left sample before a restart.
    riff_head(TAG_RIFF, TAG_WAVE, 1'b0);
    fmt_chunk(16'd2, 32'd48000, 16);
    data_head();
    put_pcm(6, 1'b0);

    while (wf_bytes < 150 || pcm_bytes < 60) begin
      if ($urandom_range(0, 99) < 78) well_formed_stream(wf_bytes, pcm_bytes);
      else broken_stream();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (byte_queue.size() > 0 || in_valid) @(negedge clk_i);
    while (frame_queue.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Run covered %0d stream bytes over %0d streams, including bad tags,",
             bytes_taken, stream_count);
    $display("oversized headers and chunks; %0d frames checked, %0d of them stereo.",
             frames_seen, stereo_frames);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
